// ===== rtl/core/mlqs_pkg.sv =====
// ----------------------------------------------------------------------------
// Multilevel queue scheduler package
// Shared widths, codes and types for the scheduler core and its parts.
// ----------------------------------------------------------------------------
package mlqs_pkg;

	localparam int QUEUE_DEPTH_DEF = 128;
	localparam int NUM_LEVELS      = 3;

	localparam int PID_W   = 16;
	localparam int PRIO_W  = 8;
	localparam int BURST_W = 16;
	localparam int ENTRY_W = PID_W + BURST_W;
	localparam int TOTAL_W = 32;
	localparam int LVL_W   = 2;
	localparam int STAT_W  = 2;

	localparam logic [BURST_W-1:0] QUANTUM_RST = BURST_W'(4);

	// Priority bands that pick the queue level on an add.
	localparam logic [PRIO_W-1:0] PRIO_L0_LO = PRIO_W'(1);
	localparam logic [PRIO_W-1:0] PRIO_L0_HI = PRIO_W'(3);
	localparam logic [PRIO_W-1:0] PRIO_L1_LO = PRIO_W'(4);
	localparam logic [PRIO_W-1:0] PRIO_L1_HI = PRIO_W'(6);

	localparam logic [LVL_W-1:0] LVL_RR    = LVL_W'(0);
	localparam logic [LVL_W-1:0] LVL_MID   = LVL_W'(1);
	localparam logic [LVL_W-1:0] LVL_LOW   = LVL_W'(2);

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_SCHED = 1'b1;

	typedef enum logic [STAT_W-1:0] {
		ST_ADDED   = 2'd0,
		ST_DROPPED = 2'd1,
		ST_RAN     = 2'd2,
		ST_IDLE    = 2'd3
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] sum;
		logic               carry;
	} alu_res_t;

endpackage

// ===== rtl/core/mlqs_if.sv =====
// ----------------------------------------------------------------------------
// Multilevel queue scheduler channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface mlqs_req_if;
	logic                         valid;
	logic                         ready;
	logic                         operation;
	logic [mlqs_pkg::PID_W-1:0]   pid;
	logic [mlqs_pkg::PRIO_W-1:0]  priority_req;
	logic [mlqs_pkg::BURST_W-1:0] burst_ticks;

	modport source (output valid, operation, pid, priority_req, burst_ticks, input ready);
	modport sink (input valid, operation, pid, priority_req, burst_ticks, output ready);
endinterface

interface mlqs_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [mlqs_pkg::STAT_W-1:0]  status;
	logic [mlqs_pkg::PID_W-1:0]   run_pid;
	logic [mlqs_pkg::LVL_W-1:0]   level;
	logic [mlqs_pkg::BURST_W-1:0] run_time;
	logic                         finished;
	logic [mlqs_pkg::TOTAL_W-1:0] total_time;

	modport source (output valid, status, run_pid, level, run_time, finished, total_time,
		input ready);
	modport sink (input valid, status, run_pid, level, run_time, finished, total_time,
		output ready);
endinterface

// ===== rtl/core/multilevel_queue_scheduler.sv =====
// ----------------------------------------------------------------------------
// Multilevel queue scheduler
// Three process FIFOs in synchronous RAM, served by priority, with a
// round-robin top level and first-come-first-served lower levels.
// ----------------------------------------------------------------------------
// Each request transaction is either an add or a schedule and yields exactly
// one response transaction. An add puts {pid, burst} into level 0 (priority
// 1 to 3), level 1 (priority 4 to 6) or level 2 (all other priorities), or
// reports it dropped when that level's FIFO holds QUEUE_DEPTH entries. A
// schedule serves the lowest-numbered non-empty level: level 0 runs its head
// for min(quantum, remaining) ticks and requeues it at the tail if work is
// left; levels 1 and 2 run their head to completion. All executed ticks go
// into a 32-bit total that saturates. The block handles one transaction at a
// time. An add, or a schedule that finds every level empty, goes from the
// decode step straight to the response step; a schedule that serves a
// process goes through the registered RAM read followed by three passes
// through the single shared adder (slice compare, remaining update, total
// update). A finished response waits in an output register, so the next
// request is accepted while it is still pending; the block only stalls
// when a second response is ready before the first has been taken.
// Queue contents need no clearing after reset; the block is ready at once.
// The quantum register may only be written while the block is idle.
// ----------------------------------------------------------------------------
module multilevel_queue_scheduler #(
	parameter int QUEUE_DEPTH = mlqs_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mlqs_req_if.sink                     req,
	mlqs_rsp_if.source                   rsp,
	input  logic                         quantum_wr_en,
	input  logic [mlqs_pkg::BURST_W-1:0] quantum_wr_data
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int NL    = mlqs_pkg::NUM_LEVELS;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_READ,
		S_CMP,
		S_SUB,
		S_ADD,
		S_DONE
	} state_t;

	state_t state_q;

	// Configuration.
	logic [mlqs_pkg::BURST_W-1:0] quantum_q;

	// FIFO bookkeeping, one entry per level.
	logic [PTR_W-1:0] head_q  [NL];
	logic [PTR_W-1:0] tail_q  [NL];
	logic [CNT_W-1:0] count_q [NL];

	// Working copy of the transaction in flight.
	logic                          op_q;
	logic [mlqs_pkg::PID_W-1:0]    pid_q;
	logic [mlqs_pkg::PRIO_W-1:0]   prio_q;
	logic [mlqs_pkg::BURST_W-1:0]  rem_q;
	logic [mlqs_pkg::BURST_W-1:0]  rtime_q;
	logic [mlqs_pkg::LVL_W-1:0]    lvl_q;
	logic                          fin_q;
	mlqs_pkg::status_t             stat_q;
	logic [mlqs_pkg::TOTAL_W-1:0]  total_q;

	// Response register.
	logic                          rsp_valid_q;
	mlqs_pkg::status_t             rsp_stat_q;
	logic [mlqs_pkg::PID_W-1:0]    rsp_pid_q;
	logic [mlqs_pkg::LVL_W-1:0]    rsp_lvl_q;
	logic [mlqs_pkg::BURST_W-1:0]  rsp_rtime_q;
	logic                          rsp_fin_q;
	logic [mlqs_pkg::TOTAL_W-1:0]  rsp_total_q;
	logic                          rsp_load;

	// Level decode: band lookup for adds, first non-empty level for schedules.
	logic [mlqs_pkg::LVL_W-1:0] add_lvl;
	logic [mlqs_pkg::LVL_W-1:0] sched_lvl;
	logic                       all_empty;
	logic [mlqs_pkg::LVL_W-1:0] dec_lvl;
	logic [mlqs_pkg::LVL_W-1:0] sel_lvl;
	logic                       sel_full;

	always_comb begin
		if (prio_q >= mlqs_pkg::PRIO_L0_LO && prio_q <= mlqs_pkg::PRIO_L0_HI) begin
			add_lvl = mlqs_pkg::LVL_RR;
		end else if (prio_q >= mlqs_pkg::PRIO_L1_LO && prio_q <= mlqs_pkg::PRIO_L1_HI) begin
			add_lvl = mlqs_pkg::LVL_MID;
		end else begin
			add_lvl = mlqs_pkg::LVL_LOW;
		end
	end

	always_comb begin
		all_empty = 1'b0;
		if (count_q[0] != '0) begin
			sched_lvl = mlqs_pkg::LVL_RR;
		end else if (count_q[1] != '0) begin
			sched_lvl = mlqs_pkg::LVL_MID;
		end else begin
			sched_lvl = mlqs_pkg::LVL_LOW;
			all_empty = (count_q[2] == '0);
		end
	end

	assign dec_lvl  = (op_q == mlqs_pkg::OP_ADD) ? add_lvl : sched_lvl;
	assign sel_lvl  = (state_q == S_DECODE) ? dec_lvl : lvl_q;
	assign sel_full = (count_q[sel_lvl] == CNT_W'(QUEUE_DEPTH));

	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		ptr_next = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	// RAM port control. New entries are written at the decode step of an add;
	// a round-robin process with work left is written back at the total step.
	logic                          do_push_add;
	logic                          do_requeue;
	logic                          do_pop;
	logic [mlqs_pkg::ENTRY_W-1:0]  wr_data;
	logic [PTR_W-1:0]              wr_addr;
	logic [PTR_W-1:0]              rd_addr;
	logic [NL-1:0]                 wr_en;
	logic [NL-1:0]                 rd_en;
	logic [mlqs_pkg::ENTRY_W-1:0]  rd_data [NL];

	assign do_push_add = (state_q == S_DECODE) && (op_q == mlqs_pkg::OP_ADD) && !sel_full;
	assign do_pop      = (state_q == S_DECODE) && (op_q == mlqs_pkg::OP_SCHED) && !all_empty;
	assign do_requeue  = (state_q == S_ADD) && (lvl_q == mlqs_pkg::LVL_RR) && !fin_q;
	assign wr_data     = {pid_q, rem_q};
	assign wr_addr     = tail_q[sel_lvl];
	assign rd_addr     = head_q[sel_lvl];

	for (genvar l = 0; l < NL; l++) begin : g_level
		assign wr_en[l] = (do_push_add || do_requeue) && (sel_lvl == mlqs_pkg::LVL_W'(l));
		assign rd_en[l] = do_pop && (sel_lvl == mlqs_pkg::LVL_W'(l));

		mlqs_ram #(
			.WIDTH (mlqs_pkg::ENTRY_W),
			.DEPTH (QUEUE_DEPTH)
		) u_store (
			.clk     (clk),
			.wr_en   (wr_en[l]),
			.wr_addr (wr_addr),
			.wr_data (wr_data),
			.rd_en   (rd_en[l]),
			.rd_addr (rd_addr),
			.rd_data (rd_data[l])
		);
	end

	// Shared adder. Compare step: quantum - remaining, a borrow means the
	// quantum is the shorter. Update step: remaining - run time. Total step:
	// total + run time, with the carry selecting saturation.
	mlqs_pkg::alu_op_t            alu_op;
	logic [mlqs_pkg::TOTAL_W-1:0] alu_a;
	logic [mlqs_pkg::TOTAL_W-1:0] alu_b;
	mlqs_pkg::alu_res_t           alu_res;

	always_comb begin
		case (state_q)
			S_CMP: begin
				alu_op = mlqs_pkg::ALU_SUB;
				alu_a  = mlqs_pkg::TOTAL_W'(quantum_q);
				alu_b  = mlqs_pkg::TOTAL_W'(rem_q);
			end
			S_SUB: begin
				alu_op = mlqs_pkg::ALU_SUB;
				alu_a  = mlqs_pkg::TOTAL_W'(rem_q);
				alu_b  = mlqs_pkg::TOTAL_W'(rtime_q);
			end
			default: begin
				alu_op = mlqs_pkg::ALU_ADD;
				alu_a  = total_q;
				alu_b  = mlqs_pkg::TOTAL_W'(rtime_q);
			end
		endcase
	end

	mlqs_alu u_alu (
		.op  (alu_op),
		.a   (alu_a),
		.b   (alu_b),
		.res (alu_res)
	);

	assign req.ready = (state_q == S_IDLE);

	// The response register takes a new response when it is empty or when its
	// current one is being taken in the same cycle.
	assign rsp_load = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			quantum_q   <= mlqs_pkg::QUANTUM_RST;
			for (int l = 0; l < NL; l++) begin
				head_q[l]  <= '0;
				tail_q[l]  <= '0;
				count_q[l] <= '0;
			end
			op_q        <= mlqs_pkg::OP_ADD;
			pid_q       <= '0;
			prio_q      <= '0;
			rem_q       <= '0;
			rtime_q     <= '0;
			lvl_q       <= '0;
			fin_q       <= 1'b0;
			stat_q      <= mlqs_pkg::ST_IDLE;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_stat_q  <= mlqs_pkg::ST_IDLE;
			rsp_pid_q   <= '0;
			rsp_lvl_q   <= '0;
			rsp_rtime_q <= '0;
			rsp_fin_q   <= 1'b0;
			rsp_total_q <= '0;
		end else begin
			if (quantum_wr_en) begin
				quantum_q <= quantum_wr_data;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q    <= req.operation;
						pid_q   <= req.pid;
						prio_q  <= req.priority_req;
						rem_q   <= req.burst_ticks;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					rtime_q <= '0;
					fin_q   <= 1'b0;
					lvl_q   <= dec_lvl;
					if (op_q == mlqs_pkg::OP_ADD) begin
						if (sel_full) begin
							stat_q <= mlqs_pkg::ST_DROPPED;
						end else begin
							stat_q           <= mlqs_pkg::ST_ADDED;
							tail_q[sel_lvl]  <= ptr_next(tail_q[sel_lvl]);
							count_q[sel_lvl] <= count_q[sel_lvl] + 1'b1;
						end
						state_q <= S_DONE;
					end else if (all_empty) begin
						stat_q  <= mlqs_pkg::ST_IDLE;
						pid_q   <= '0;
						lvl_q   <= mlqs_pkg::LVL_RR;
						state_q <= S_DONE;
					end else begin
						head_q[sel_lvl]  <= ptr_next(head_q[sel_lvl]);
						count_q[sel_lvl] <= count_q[sel_lvl] - 1'b1;
						state_q          <= S_READ;
					end
				end
				S_READ: begin
					pid_q   <= rd_data[lvl_q][mlqs_pkg::ENTRY_W-1:mlqs_pkg::BURST_W];
					rem_q   <= rd_data[lvl_q][mlqs_pkg::BURST_W-1:0];
					state_q <= S_CMP;
				end
				S_CMP: begin
					// Only level 0 is cut to the quantum.
					if (lvl_q == mlqs_pkg::LVL_RR && !alu_res.carry) begin
						rtime_q <= quantum_q;
					end else begin
						rtime_q <= rem_q;
					end
					state_q <= S_SUB;
				end
				S_SUB: begin
					rem_q   <= alu_res.sum[mlqs_pkg::BURST_W-1:0];
					fin_q   <= (alu_res.sum[mlqs_pkg::BURST_W-1:0] == '0);
					stat_q  <= mlqs_pkg::ST_RAN;
					state_q <= S_ADD;
				end
				S_ADD: begin
					total_q <= alu_res.carry ? '1 : alu_res.sum;
					if (do_requeue) begin
						tail_q[sel_lvl]  <= ptr_next(tail_q[sel_lvl]);
						count_q[sel_lvl] <= count_q[sel_lvl] + 1'b1;
					end
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_stat_q  <= stat_q;
						rsp_pid_q   <= pid_q;
						rsp_lvl_q   <= lvl_q;
						rsp_rtime_q <= rtime_q;
						rsp_fin_q   <= fin_q;
						rsp_total_q <= total_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = rsp_stat_q;
	assign rsp.run_pid    = rsp_pid_q;
	assign rsp.level      = rsp_lvl_q;
	assign rsp.run_time   = rsp_rtime_q;
	assign rsp.finished   = rsp_fin_q;
	assign rsp.total_time = rsp_total_q;

endmodule

// ===== rtl/core/mlqs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module mlqs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== rtl/core/mlqs_alu.sv =====
// ----------------------------------------------------------------------------
// Scheduler arithmetic unit
// One shared adder/subtractor with carry out, used for the slice compare,
// the remaining-burst update and the running total.
// ----------------------------------------------------------------------------
module mlqs_alu (
	input  mlqs_pkg::alu_op_t               op,
	input  logic [mlqs_pkg::TOTAL_W-1:0]    a,
	input  logic [mlqs_pkg::TOTAL_W-1:0]    b,
	output mlqs_pkg::alu_res_t              res
);

	logic [mlqs_pkg::TOTAL_W:0]   wide;
	logic [mlqs_pkg::TOTAL_W-1:0] b_eff;

	// Subtraction is a + ~b + 1; a set carry then means no borrow.
	assign b_eff = (op == mlqs_pkg::ALU_SUB) ? ~b : b;
	assign wide  = {1'b0, a} + {1'b0, b_eff}
		+ {{mlqs_pkg::TOTAL_W{1'b0}}, (op == mlqs_pkg::ALU_SUB)};
	assign res.sum   = wide[mlqs_pkg::TOTAL_W-1:0];
	assign res.carry = wide[mlqs_pkg::TOTAL_W];

endmodule

// ===== rtl/core/mlqs_checker.sv =====
// ----------------------------------------------------------------------------
// Multilevel queue scheduler checker
// Port-level assertions on the scheduler, attached by bind.
// ----------------------------------------------------------------------------
module mlqs_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         req_valid,
	input logic                         req_ready,
	input logic                         rsp_valid,
	input logic                         rsp_ready,
	input logic [mlqs_pkg::STAT_W-1:0]  rsp_status,
	input logic [mlqs_pkg::PID_W-1:0]   rsp_run_pid,
	input logic [mlqs_pkg::LVL_W-1:0]   rsp_level,
	input logic [mlqs_pkg::BURST_W-1:0] rsp_run_time,
	input logic                         rsp_finished,
	input logic [mlqs_pkg::TOTAL_W-1:0] rsp_total_time
);

	// One transaction at a time: the block is busy right after an accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while previous one in progress");

	// A pending response holds until taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_total_time)
			&& $stable(rsp_status) && $stable(rsp_run_pid))
		else $error("pending response changed");

	// Idle responses carry no pid, level, run time or finished flag.
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == mlqs_pkg::ST_IDLE |->
			rsp_run_pid == '0 && rsp_level == '0 && rsp_run_time == '0 && !rsp_finished)
		else $error("idle response with payload");

	// Adds run nothing, and the lower levels always run to completion.
	a_add_no_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == mlqs_pkg::ST_ADDED || rsp_status == mlqs_pkg::ST_DROPPED)
			|-> rsp_run_time == '0 && !rsp_finished)
		else $error("add response reports run time");

	a_fcfs_complete: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status == mlqs_pkg::ST_RAN && rsp_level != mlqs_pkg::LVL_RR
			|-> rsp_finished)
		else $error("lower level slice did not complete");

endmodule

bind multilevel_queue_scheduler mlqs_checker u_mlqs_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.req_valid      (req.valid),
	.req_ready      (req.ready),
	.rsp_valid      (rsp.valid),
	.rsp_ready      (rsp.ready),
	.rsp_status     (rsp.status),
	.rsp_run_pid    (rsp.run_pid),
	.rsp_level      (rsp.level),
	.rsp_run_time   (rsp.run_time),
	.rsp_finished   (rsp.finished),
	.rsp_total_time (rsp.total_time)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// Multilevel queue scheduler testbench
// Drives add and schedule requests with random gaps, predicts every response
// with a behavioral copy of the three-level queues, and compares each
// response transaction field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	// The run is bounded by a cycle budget. A correct run has about 2,100
	// transactions, each with its pass through the block plus a sender gap and
	// a receiver stall, and one long hold-off; the limit below leaves a wide
	// margin for all of that.
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_TAIL  = 20;
	localparam int HALF_PERIOD = 4;

	// One queued process: pid and the service ticks it still needs.
	typedef struct packed {
		logic [mlqs_pkg::PID_W-1:0]   pid;
		logic [mlqs_pkg::BURST_W-1:0] remaining;
	} proc_entry_t;

	// One response transaction as the block presents it.
	typedef struct packed {
		mlqs_pkg::status_t            status;
		logic [mlqs_pkg::PID_W-1:0]   run_pid;
		logic [mlqs_pkg::LVL_W-1:0]   level;
		logic [mlqs_pkg::BURST_W-1:0] run_time;
		logic                         finished;
		logic [mlqs_pkg::TOTAL_W-1:0] total_time;
	} sched_result_t;

	// The scoreboard keeps its own copy of the queues, the quantum and the
	// running total, and turns every accepted request into the response that
	// the block must return for it.
	class sched_scoreboard;
		logic [mlqs_pkg::BURST_W-1:0] quantum;
		logic [mlqs_pkg::TOTAL_W-1:0] total_ticks;
		proc_entry_t                  level_fifo[mlqs_pkg::NUM_LEVELS][$];
		sched_result_t                expected_q[$];
		int                           errors;
		int                           resp_count;

		function new();
			quantum     = mlqs_pkg::QUANTUM_RST;
			total_ticks = '0;
			errors      = 0;
			resp_count  = 0;
		endfunction

		task report(string msg);
			errors++;
			$display("ERROR: response %0d: %s", resp_count, msg);
		endtask

		function bit queues_empty();
			return level_fifo[0].size() == 0 && level_fifo[1].size() == 0 &&
				level_fifo[2].size() == 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Priority bands pick the level of an add.
		function int level_of(logic [mlqs_pkg::PRIO_W-1:0] prio);
			if (prio >= mlqs_pkg::PRIO_L0_LO && prio <= mlqs_pkg::PRIO_L0_HI)
				return int'(mlqs_pkg::LVL_RR);
			if (prio >= mlqs_pkg::PRIO_L1_LO && prio <= mlqs_pkg::PRIO_L1_HI)
				return int'(mlqs_pkg::LVL_MID);
			return int'(mlqs_pkg::LVL_LOW);
		endfunction

		function void note_request(logic op, logic [mlqs_pkg::PID_W-1:0] pid,
			logic [mlqs_pkg::PRIO_W-1:0] prio, logic [mlqs_pkg::BURST_W-1:0] burst);
			sched_result_t                res;
			proc_entry_t                  proc;
			int                           lvl;
			logic [mlqs_pkg::BURST_W-1:0] ticks;
			logic [mlqs_pkg::TOTAL_W:0]   sum;
			res = '0;
			if (op == mlqs_pkg::OP_ADD) begin
				lvl         = level_of(prio);
				res.run_pid = pid;
				res.level   = mlqs_pkg::LVL_W'(lvl);
				if (level_fifo[lvl].size() >= mlqs_pkg::QUEUE_DEPTH_DEF) begin
					res.status = mlqs_pkg::ST_DROPPED;
				end else begin
					proc.pid       = pid;
					proc.remaining = burst;
					level_fifo[lvl].push_back(proc);
					res.status = mlqs_pkg::ST_ADDED;
				end
			end else begin
				lvl = -1;
				for (int l = mlqs_pkg::NUM_LEVELS - 1; l >= 0; l--)
					if (level_fifo[l].size() != 0)
						lvl = l;
				if (lvl < 0) begin
					res.status = mlqs_pkg::ST_IDLE;
				end else begin
					proc        = level_fifo[lvl].pop_front();
					res.status  = mlqs_pkg::ST_RAN;
					res.run_pid = proc.pid;
					res.level   = mlqs_pkg::LVL_W'(lvl);
					if (lvl == int'(mlqs_pkg::LVL_RR)) begin
						// Round robin: one slice, and back to the tail if work is left.
						ticks          = (quantum < proc.remaining) ? quantum : proc.remaining;
						proc.remaining = proc.remaining - ticks;
						if (proc.remaining != 0) begin
							level_fifo[lvl].push_back(proc);
							res.finished = 1'b0;
						end else begin
							res.finished = 1'b1;
						end
					end else begin
						ticks        = proc.remaining;
						res.finished = 1'b1;
					end
					res.run_time = ticks;
					sum          = {1'b0, total_ticks} + (mlqs_pkg::TOTAL_W + 1)'(ticks);
					total_ticks  = sum[mlqs_pkg::TOTAL_W] ? '1 : sum[mlqs_pkg::TOTAL_W-1:0];
				end
			end
			res.total_time = total_ticks;
			expected_q.push_back(res);
		endfunction

		task compare_field(string name, logic [mlqs_pkg::TOTAL_W-1:0] got,
			logic [mlqs_pkg::TOTAL_W-1:0] want);
			if (got !== want)
				report($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
		endtask

		task check_response(sched_result_t got);
			sched_result_t want;
			resp_count++;
			if (expected_q.size() == 0) begin
				report("response with no request outstanding");
				return;
			end
			want = expected_q.pop_front();
			compare_field("status", mlqs_pkg::TOTAL_W'(got.status),
				mlqs_pkg::TOTAL_W'(want.status));
			compare_field("run_pid", mlqs_pkg::TOTAL_W'(got.run_pid),
				mlqs_pkg::TOTAL_W'(want.run_pid));
			compare_field("level", mlqs_pkg::TOTAL_W'(got.level),
				mlqs_pkg::TOTAL_W'(want.level));
			compare_field("run_time", mlqs_pkg::TOTAL_W'(got.run_time),
				mlqs_pkg::TOTAL_W'(want.run_time));
			compare_field("finished", mlqs_pkg::TOTAL_W'(got.finished),
				mlqs_pkg::TOTAL_W'(want.finished));
			compare_field("total_time", got.total_time, want.total_time);
		endtask

		task check_all_taken();
			if (expected_q.size() != 0)
				report($sformatf("%0d responses never arrived", expected_q.size()));
		endtask
	endclass

	logic                         clk;
	logic                         arst_n;
	logic                         quantum_wr_en;
	logic [mlqs_pkg::BURST_W-1:0] quantum_wr_data;

	mlqs_req_if req_ch();
	mlqs_rsp_if rsp_ch();

	sched_scoreboard sb;

	// Idling controls shared between the stimulus and the response side.
	bit tx_idle_en;
	bit rx_idle_en;
	int hold_off_cycles;
	int cycle_count;

	multilevel_queue_scheduler u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.req             (req_ch),
		.rsp             (rsp_ch),
		.quantum_wr_en   (quantum_wr_en),
		.quantum_wr_data (quantum_wr_data)
	);

	always begin
		clk = 1'b0;
		#HALF_PERIOD;
		clk = 1'b1;
		#HALF_PERIOD;
	end

	// Run-length guard: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Idle lengths: mostly none or short, now and then a long one.
	function automatic int pick_idle(bit en);
		int r;
		if (!en)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one request and holds it until the block takes it. The prediction
	// is made right at acceptance, so the stimulus can look at the predicted
	// queue state when it picks the next request. If no gap follows, valid stays
	// high and the next call simply puts new fields on the same edge.
	task automatic issue_request(logic op, logic [mlqs_pkg::PID_W-1:0] pid,
		logic [mlqs_pkg::PRIO_W-1:0] prio, logic [mlqs_pkg::BURST_W-1:0] burst);
		int gap;
		req_ch.valid        <= 1'b1;
		req_ch.operation    <= op;
		req_ch.pid          <= pid;
		req_ch.priority_req <= prio;
		req_ch.burst_ticks  <= burst;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		sb.note_request(op, pid, prio, burst);
		gap = pick_idle(tx_idle_en);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// A schedule request; its pid, priority and burst fields carry random junk.
	task automatic issue_sched();
		issue_request(mlqs_pkg::OP_SCHED, mlqs_pkg::PID_W'($urandom),
			mlqs_pkg::PRIO_W'($urandom), mlqs_pkg::BURST_W'($urandom));
	endtask

	// A random request. Priorities lean toward the two low bands so that all
	// three levels are busy, and bursts are mostly short so that level 0
	// processes go around the round robin several times.
	task automatic issue_random(int sched_pct);
		logic                         op;
		logic [mlqs_pkg::PRIO_W-1:0]  prio;
		logic [mlqs_pkg::BURST_W-1:0] burst;
		int                           r;
		op = ($urandom_range(0, 99) < sched_pct) ? mlqs_pkg::OP_SCHED : mlqs_pkg::OP_ADD;
		r  = $urandom_range(0, 9);
		if (r < 3)
			prio = mlqs_pkg::PRIO_W'($urandom_range(mlqs_pkg::PRIO_L0_LO,
				mlqs_pkg::PRIO_L0_HI));
		else if (r < 5)
			prio = mlqs_pkg::PRIO_W'($urandom_range(mlqs_pkg::PRIO_L1_LO,
				mlqs_pkg::PRIO_L1_HI));
		else if (r == 5)
			prio = '0;
		else
			prio = mlqs_pkg::PRIO_W'($urandom);
		r = $urandom_range(0, 99);
		if (r < 70)
			burst = mlqs_pkg::BURST_W'($urandom_range(0, 12));
		else if (r < 85)
			burst = mlqs_pkg::BURST_W'($urandom_range(0, 300));
		else
			burst = mlqs_pkg::BURST_W'($urandom);
		issue_request(op, mlqs_pkg::PID_W'($urandom), prio, burst);
	endtask

	// The sender stops and waits until every predicted response has come back,
	// which leaves the block idle.
	task automatic wait_drain();
		req_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Quantum writes happen only while the block is idle.
	task automatic write_quantum(logic [mlqs_pkg::BURST_W-1:0] q);
		req_ch.valid    <= 1'b0;
		quantum_wr_en   <= 1'b1;
		quantum_wr_data <= q;
		@(posedge clk);
		quantum_wr_en <= 1'b0;
		sb.quantum = q;
	endtask

	// Fills one level past its depth so that the last adds are dropped, then
	// schedules until every queue is empty and once more to see the idle case.
	task automatic fill_and_drain(int lvl);
		logic [mlqs_pkg::PRIO_W-1:0] prio;
		for (int i = 0; i < mlqs_pkg::QUEUE_DEPTH_DEF + 3; i++) begin
			if (lvl == int'(mlqs_pkg::LVL_RR))
				prio = mlqs_pkg::PRIO_W'($urandom_range(mlqs_pkg::PRIO_L0_LO,
					mlqs_pkg::PRIO_L0_HI));
			else if (lvl == int'(mlqs_pkg::LVL_MID))
				prio = mlqs_pkg::PRIO_W'($urandom_range(mlqs_pkg::PRIO_L1_LO,
					mlqs_pkg::PRIO_L1_HI));
			else
				prio = ($urandom_range(0, 1) != 0) ? 8'(0) : 8'($urandom_range(7, 255));
			issue_request(mlqs_pkg::OP_ADD, mlqs_pkg::PID_W'($urandom), prio,
				mlqs_pkg::BURST_W'($urandom_range(0, 8)));
		end
		while (!sb.queues_empty())
			issue_sched();
		issue_sched();
	endtask

	// Response side: check every accepted response, then decide ready for the
	// next cycle. A long hold-off requested by the stimulus overrides the
	// random stalls and is counted down here, one cycle at a time.
	initial begin
		sched_result_t got;
		int            n;
		int            stall_left;
		stall_left = 0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				got.status     = mlqs_pkg::status_t'(rsp_ch.status);
				got.run_pid    = rsp_ch.run_pid;
				got.level      = rsp_ch.level;
				got.run_time   = rsp_ch.run_time;
				got.finished   = rsp_ch.finished;
				got.total_time = rsp_ch.total_time;
				sb.check_response(got);
			end
			if (hold_off_cycles > 0) begin
				hold_off_cycles--;
				rsp_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rsp_ch.ready <= 1'b0;
			end else begin
				n = pick_idle(rx_idle_en);
				if (n > 0) begin
					stall_left = n - 1;
					rsp_ch.ready <= 1'b0;
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Stimulus sequence.
	initial begin
		logic [mlqs_pkg::BURST_W-1:0] q;
		sb              = new();
		tx_idle_en      = 1'b0;
		rx_idle_en      = 1'b0;
		hold_off_cycles = 0;
		arst_n               <= 1'b0;
		req_ch.valid         <= 1'b0;
		req_ch.operation     <= mlqs_pkg::OP_ADD;
		req_ch.pid           <= '0;
		req_ch.priority_req  <= '0;
		req_ch.burst_ticks   <= '0;
		quantum_wr_en        <= 1'b0;
		quantum_wr_data      <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_en = 1'b1;
		rx_idle_en = 1'b1;

		// Directed part, with the quantum still at its reset value of 4. A
		// schedule on empty queues comes first. The adds then cover the edges
		// of every priority band, zero and full pid and burst, and a zero burst
		// on level 0. The schedules drain all three levels in order and end on
		// the idle case again.
		issue_request(mlqs_pkg::OP_SCHED, 16'h0000, 8'h00, 16'h0000);
		issue_request(mlqs_pkg::OP_ADD, 16'h0000, 8'd0, 16'h0000);
		issue_request(mlqs_pkg::OP_ADD, 16'hFFFF, 8'd255, 16'hFFFF);
		issue_request(mlqs_pkg::OP_ADD, 16'h0001, 8'd1, 16'd10);
		issue_request(mlqs_pkg::OP_ADD, 16'h0002, 8'd3, 16'd0);
		issue_request(mlqs_pkg::OP_ADD, 16'h0003, 8'd4, 16'd5);
		issue_request(mlqs_pkg::OP_ADD, 16'h0004, 8'd6, 16'hFFFF);
		issue_request(mlqs_pkg::OP_ADD, 16'h0005, 8'd7, 16'd1);
		issue_request(mlqs_pkg::OP_ADD, 16'h0006, 8'd2, 16'd4);
		repeat (11) issue_sched();

		// A zero quantum runs level 0 slices of no ticks: the unfinished process
		// keeps coming back unchanged, while a zero burst still completes.
		wait_drain();
		write_quantum('0);
		issue_request(mlqs_pkg::OP_ADD, 16'h0007, 8'd2, 16'd3);
		issue_request(mlqs_pkg::OP_ADD, 16'h0008, 8'd1, 16'd0);
		repeat (3) issue_sched();

		// The largest quantum finishes the stuck process in one slice.
		wait_drain();
		write_quantum(16'hFFFF);
		repeat (2) issue_sched();

		// Random rounds, each with its own quantum. One round runs with no
		// idling at all, and one starts with a long receiver hold-off while the
		// sender keeps offering, so that the output register fills and the
		// request channel backs up.
		for (int rnd = 0; rnd < 6; rnd++) begin
			case (rnd)
				0: q = 16'd1;
				1: q = 16'hFFFF;
				2: q = 16'd3;
				3: q = mlqs_pkg::BURST_W'($urandom_range(1, 16));
				4: q = mlqs_pkg::BURST_W'($urandom);
				default: q = 16'd2;
			endcase
			wait_drain();
			write_quantum(q);
			tx_idle_en = (rnd != 2);
			rx_idle_en = (rnd != 2);
			if (rnd == 3) begin
				tx_idle_en      = 1'b0;
				hold_off_cycles = 300;
				repeat (30) issue_random(50);
				tx_idle_en = 1'b1;
			end
			repeat (180) issue_random((rnd % 2 == 0) ? 40 : 55);
		end

		// Full queues on each level, with the drops that follow. The largest
		// quantum finishes every level 0 process in one slice, which keeps the
		// drains short even when long processes are left from the random rounds.
		wait_drain();
		write_quantum(16'hFFFF);
		for (int lvl = 0; lvl < mlqs_pkg::NUM_LEVELS; lvl++)
			fill_and_drain(lvl);

		repeat (20) issue_random(45);

		// All stimulus is in; let the remaining responses come back, then give
		// the block a few more cycles in case it sends anything unasked for.
		wait_drain();
		repeat (DRAIN_TAIL) @(posedge clk);
		sb.check_all_taken();
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
